// ===== rtl/core/sdhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Shared types, codes and constants of the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
package sdhs_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned STORE_AW    = $clog2(BLOCK_BYTES);

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_LOAD  = 3'd2,
    OP_WRITE = 3'd3,
    OP_CARD  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_R1       = 3'd1,
    ERR_TOKEN    = 3'd2,
    ERR_REJECT   = 3'd3,
    ERR_BUSY     = 3'd4,
    ERR_VERIFY   = 3'd5,
    ERR_INIT     = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    REG_R1_POLL    = 3'd0,
    REG_TOKEN_POLL = 3'd1,
    REG_BUSY_POLL  = 3'd2,
    REG_INIT_ATT   = 3'd3,
    REG_READ_ATT   = 3'd4,
    REG_WRITE_ATT  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_DUMMY, PH_CMD, PH_R1, PH_R7, PH_OCR, PH_TRAIL,
    PH_TOKEN, PH_DIN, PH_WDATA, PH_DRESP, PH_BUSY
  } phase_t;

  typedef enum logic [1:0] {
    M_NONE, M_INIT, M_READ, M_WRITE
  } mode_t;

  typedef enum logic [3:0] {
    A_C8, A_LOOP, A_C55, A_C41, A_C58, A_INIT_END, A_TOKEN, A_WDATA,
    A_VERIFY, A_FAIL, A_OK
  } act_t;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_READ_BLK  = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] R7_ECHO    = 8'hAA;
  localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS   = 32'h4000_0000;

  typedef struct packed {
    logic [15:0] r1_poll_limit;
    logic [15:0] token_poll_limit;
    logic [19:0] busy_poll_limit;
    logic [15:0] init_attempt_limit;
    logic [3:0]  read_attempts;
    logic [3:0]  write_attempts;
  } cfg_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       chip_select;
    logic       slow_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic       success;
    logic [2:0] error_code;
    logic       is_sdhc;
    logic [1:0] card_version;
  } res_t;

  // Attempt limits: zero acts as one, anything above eight acts as eight.
  function automatic logic [3:0] att_lim(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    if (x == 4'd0) r = 4'd1;
    else if (x > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ===== rtl/core/sdhs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sdhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sdhs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host sequencer control
// Steps the init, read and write sequences one beat at a time and drives
// the block store ports.
// ----------------------------------------------------------------------------
module sdhs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [2:0]                      operation,
  input  logic [31:0]                     block_address,
  input  logic [7:0]                      write_byte,
  input  logic [7:0]                      card_byte,
  input  sdhs_pkg::cfg_t                  cfg,
  input  logic [7:0]                      store_rdata,
  output logic                            store_we,
  output logic [sdhs_pkg::STORE_AW-1:0]   store_waddr,
  output logic [7:0]                      store_wdata,
  output logic [sdhs_pkg::STORE_AW-1:0]   store_raddr,
  output sdhs_pkg::res_t                  res
);
  import sdhs_pkg::*;

  phase_t      phase, phase_next;
  mode_t       mode, mode_next;
  act_t        next_act, next_act_next;
  logic [9:0]  byte_counter, byte_counter_next;
  logic [19:0] poll_counter, poll_counter_next;
  logic [15:0] attempt_counter, attempt_counter_next;
  logic [3:0]  retry_counter, retry_counter_next;
  logic [31:0] response_shift, response_shift_next;
  logic [31:0] address_hold, address_hold_next;
  logic        sdhc_flag, sdhc_flag_next;
  logic [1:0]  version_hold, version_hold_next;
  logic        verify_ok, verify_ok_next;
  logic [2:0]  error_hold, error_hold_next;
  logic        init_ok, init_ok_next;
  logic        fast_clock, fast_clock_next;
  logic [STORE_AW-1:0] load_index, load_index_next;
  logic [5:0]  cmd_code, cmd_code_next;
  logic [7:0]  cmd_crc, cmd_crc_next;
  logic [31:0] cmd_arg, cmd_arg_next;

  // Deferred actions resolved after the per-phase step.
  logic        st_cmd, trail, act_go, init_go, init_end_go, attempt_go, fin;
  logic [5:0]  sc_code;
  logic [31:0] sc_arg;
  logic [7:0]  sc_crc;
  logic [2:0]  tr_n;
  act_t        tr_act, act;
  logic        fin_ok;
  logic [2:0]  fin_err;
  logic        o_sv, o_cs, o_rv, o_rl;
  logic [7:0]  o_sb, o_rb;

  function automatic logic [31:0] card_addr(input logic [31:0] a, input logic hc);
    return hc ? a : {a[22:0], 9'd0};
  endfunction

  function automatic logic [7:0] cmd_byte(input logic [9:0] i, input logic [5:0] code,
                                          input logic [31:0] arg, input logic [7:0] crc);
    logic [7:0] r;
    case (i)
      10'd0:   r = {2'b01, code};
      10'd1:   r = arg[31:24];
      10'd2:   r = arg[23:16];
      10'd3:   r = arg[15:8];
      10'd4:   r = arg[7:0];
      default: r = crc;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      mode            <= M_NONE;
      next_act        <= A_OK;
      byte_counter    <= '0;
      poll_counter    <= '0;
      attempt_counter <= '0;
      retry_counter   <= '0;
      response_shift  <= '0;
      address_hold    <= '0;
      sdhc_flag       <= 1'b0;
      version_hold    <= '0;
      verify_ok       <= 1'b0;
      error_hold      <= '0;
      init_ok         <= 1'b0;
      fast_clock      <= 1'b0;
      load_index      <= '0;
      cmd_code        <= '0;
      cmd_crc         <= '0;
      cmd_arg         <= '0;
    end else begin
      phase           <= phase_next;
      mode            <= mode_next;
      next_act        <= next_act_next;
      byte_counter    <= byte_counter_next;
      poll_counter    <= poll_counter_next;
      attempt_counter <= attempt_counter_next;
      retry_counter   <= retry_counter_next;
      response_shift  <= response_shift_next;
      address_hold    <= address_hold_next;
      sdhc_flag       <= sdhc_flag_next;
      version_hold    <= version_hold_next;
      verify_ok       <= verify_ok_next;
      error_hold      <= error_hold_next;
      init_ok         <= init_ok_next;
      fast_clock      <= fast_clock_next;
      load_index      <= load_index_next;
      cmd_code        <= cmd_code_next;
      cmd_crc         <= cmd_crc_next;
      cmd_arg         <= cmd_arg_next;
    end
  end

  always_comb begin
    logic [19:0] p;
    logic        ok;
    logic        vok;
    logic [31:0] rs;
    p = poll_counter + 20'd1;
    ok = (card_byte & 8'hFE) == 8'h00;
    vok = verify_ok;
    rs = {response_shift[23:0], card_byte};

    phase_next           = phase;
    mode_next            = mode;
    next_act_next        = next_act;
    byte_counter_next    = byte_counter;
    poll_counter_next    = poll_counter;
    attempt_counter_next = attempt_counter;
    retry_counter_next   = retry_counter;
    response_shift_next  = response_shift;
    address_hold_next    = address_hold;
    sdhc_flag_next       = sdhc_flag;
    version_hold_next    = version_hold;
    verify_ok_next       = verify_ok;
    error_hold_next      = error_hold;
    init_ok_next         = init_ok;
    fast_clock_next      = fast_clock;
    load_index_next      = load_index;
    cmd_code_next        = cmd_code;
    cmd_crc_next         = cmd_crc;
    cmd_arg_next         = cmd_arg;

    st_cmd = 1'b0; trail = 1'b0; act_go = 1'b0; init_go = 1'b0;
    init_end_go = 1'b0; attempt_go = 1'b0; fin = 1'b0;
    sc_code = '0; sc_arg = '0; sc_crc = '0;
    tr_n = 3'd2; tr_act = A_OK; act = next_act;
    fin_ok = 1'b0; fin_err = ERR_NONE;
    o_sv = 1'b0; o_sb = '0; o_cs = 1'b0; o_rv = 1'b0; o_rb = '0; o_rl = 1'b0;
    store_we = 1'b0;

    if (fire) begin
      if (phase == PH_IDLE) begin
        case (operation)
          OP_INIT: begin
            mode_next = M_INIT;
            init_go = 1'b1;
          end
          OP_READ, OP_WRITE: begin
            mode_next = (operation == OP_READ) ? M_READ : M_WRITE;
            address_hold_next = block_address;
            retry_counter_next = '0;
            error_hold_next = ERR_NONE;
            if (operation == OP_WRITE) load_index_next = '0;
            attempt_go = 1'b1;
          end
          OP_LOAD: begin
            store_we = 1'b1;
            load_index_next = load_index + 1'b1;
          end
          default: ;
        endcase
      end else if (operation == OP_CARD) begin
        case (phase)
          PH_DUMMY: begin
            if (byte_counter < 10'd10) begin
              byte_counter_next = byte_counter + 10'd1;
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b0;
            end else begin
              st_cmd = 1'b1; sc_code = CMD_GO_IDLE; sc_arg = '0; sc_crc = CRC_CMD0;
            end
          end
          PH_CMD: begin
            if (byte_counter < 10'd6) begin
              o_sv = 1'b1; o_cs = 1'b1;
              o_sb = cmd_byte(byte_counter, cmd_code, cmd_arg, cmd_crc);
              byte_counter_next = byte_counter + 10'd1;
            end else begin
              phase_next = PH_R1; poll_counter_next = '0;
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end
          end
          PH_R1: begin
            poll_counter_next = p;
            if (!card_byte[7] || p >= {4'd0, cfg.r1_poll_limit}) begin
              case (cmd_code)
                CMD_GO_IDLE: begin
                  trail = 1'b1;
                  if (card_byte == 8'h01) begin
                    version_hold_next = 2'd2; tr_act = A_C8;
                  end else begin
                    tr_act = A_LOOP;
                  end
                end
                CMD_SEND_IF: begin
                  if (ok) begin
                    phase_next = PH_R7; byte_counter_next = '0;
                    o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
                  end else begin
                    version_hold_next = 2'd1; trail = 1'b1; tr_act = A_LOOP;
                  end
                end
                CMD_APP: begin
                  trail = 1'b1;
                  if (ok) begin
                    tr_act = A_C41;
                  end else begin
                    init_ok_next = 1'b0; tr_act = A_INIT_END;
                  end
                end
                CMD_OP_COND: begin
                  trail = 1'b1;
                  if (!ok) begin
                    init_ok_next = 1'b0; tr_act = A_INIT_END;
                  end else if (card_byte == 8'h00) begin
                    if (version_hold == 2'd2) begin
                      tr_act = A_C58;
                    end else begin
                      init_ok_next = 1'b1; tr_act = A_INIT_END;
                    end
                  end else begin
                    attempt_counter_next = attempt_counter + 16'd1;
                    if (attempt_counter_next >= cfg.init_attempt_limit) begin
                      init_ok_next = 1'b0; tr_act = A_INIT_END;
                    end else begin
                      tr_act = A_C55;
                    end
                  end
                end
                CMD_READ_OCR: begin
                  init_ok_next = ok;
                  phase_next = PH_OCR; byte_counter_next = '0; response_shift_next = '0;
                  o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
                end
                CMD_READ_BLK: begin
                  trail = 1'b1;
                  tr_n = (mode == M_READ) ? 3'd1 : 3'd2;
                  if (ok) begin
                    tr_act = A_TOKEN;
                  end else begin
                    error_hold_next = ERR_R1; tr_act = A_FAIL;
                  end
                end
                default: begin
                  trail = 1'b1;
                  if (ok) begin
                    tr_act = A_WDATA;
                  end else begin
                    error_hold_next = ERR_R1; tr_act = A_FAIL;
                  end
                end
              endcase
            end else begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end
          end
          PH_R7: begin
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter < 10'd2) begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end else if (byte_counter == 10'd2) begin
              if (card_byte[3:0] == 4'h1) begin
                o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
              end else begin
                version_hold_next = 2'd1; trail = 1'b1; tr_act = A_LOOP;
              end
            end else begin
              if (card_byte != R7_ECHO) version_hold_next = 2'd1;
              trail = 1'b1; tr_act = A_LOOP;
            end
          end
          PH_OCR: begin
            response_shift_next = rs;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter_next < 10'd4) begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end else begin
              sdhc_flag_next = init_ok & rs[30];
              trail = 1'b1; tr_act = A_INIT_END;
            end
          end
          PH_TRAIL: begin
            if (byte_counter != 10'd0) begin
              byte_counter_next = byte_counter - 10'd1;
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end else begin
              act_go = 1'b1;
            end
          end
          PH_TOKEN: begin
            poll_counter_next = p;
            if (card_byte == TOKEN_DATA) begin
              phase_next = PH_DIN; byte_counter_next = '0; verify_ok_next = 1'b1;
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end else if (p >= {4'd0, cfg.token_poll_limit}) begin
              error_hold_next = ERR_TOKEN;
              trail = 1'b1; tr_act = A_FAIL;
              tr_n = (mode == M_READ) ? 3'd3 : 3'd4;
            end else begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end
          end
          PH_DIN: begin
            if (mode == M_READ) begin
              o_rv = 1'b1; o_rb = card_byte;
              o_rl = (byte_counter[STORE_AW-1:0] == STORE_AW'(BLOCK_BYTES - 1));
            end else if (store_rdata != card_byte) begin
              vok = 1'b0;
            end
            verify_ok_next = vok;
            byte_counter_next = byte_counter + 10'd1;
            if (byte_counter_next < 10'(BLOCK_BYTES)) begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end else begin
              trail = 1'b1; tr_n = 3'd4;
              if (mode == M_READ || vok) begin
                tr_act = A_OK;
              end else begin
                error_hold_next = ERR_VERIFY; tr_act = A_FAIL;
              end
            end
          end
          PH_WDATA: begin
            o_sv = 1'b1; o_cs = 1'b1;
            if (byte_counter < 10'(BLOCK_BYTES)) begin
              o_sb = store_rdata;
              byte_counter_next = byte_counter + 10'd1;
            end else if (byte_counter < 10'(BLOCK_BYTES + 2)) begin
              o_sb = BYTE_IDLE;
              byte_counter_next = byte_counter + 10'd1;
            end else begin
              o_sb = BYTE_IDLE;
              phase_next = PH_DRESP;
            end
          end
          PH_DRESP: begin
            if (card_byte[4:0] != 5'h05) begin
              error_hold_next = ERR_REJECT; trail = 1'b1; tr_act = A_FAIL;
            end else begin
              phase_next = PH_BUSY; poll_counter_next = '0;
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end
          end
          PH_BUSY: begin
            poll_counter_next = p;
            if (card_byte != 8'h00) begin
              trail = 1'b1; tr_act = A_VERIFY;
            end else if (p >= cfg.busy_poll_limit) begin
              error_hold_next = ERR_BUSY; trail = 1'b1; tr_act = A_FAIL;
            end else begin
              o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (act_go) begin
      case (act)
        A_C8: begin
          st_cmd = 1'b1; sc_code = CMD_SEND_IF; sc_arg = ARG_CMD8; sc_crc = CRC_CMD8;
        end
        A_LOOP: begin
          attempt_counter_next = '0;
          st_cmd = 1'b1; sc_code = CMD_APP;
        end
        A_C55: begin
          st_cmd = 1'b1; sc_code = CMD_APP;
        end
        A_C41: begin
          st_cmd = 1'b1; sc_code = CMD_OP_COND; sc_arg = ARG_HCS;
        end
        A_C58: begin
          st_cmd = 1'b1; sc_code = CMD_READ_OCR;
        end
        A_INIT_END: init_end_go = 1'b1;
        A_TOKEN: begin
          phase_next = PH_TOKEN; poll_counter_next = '0;
          o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
        end
        A_WDATA: begin
          phase_next = PH_WDATA; byte_counter_next = '0;
          o_sv = 1'b1; o_sb = TOKEN_DATA; o_cs = 1'b1;
        end
        A_VERIFY: begin
          st_cmd = 1'b1; sc_code = CMD_READ_BLK;
          sc_arg = card_addr(address_hold, sdhc_flag);
        end
        A_FAIL: begin
          if (retry_counter < 4'd8) retry_counter_next = retry_counter + 4'd1;
          init_go = 1'b1;
        end
        default: begin
          fin = 1'b1; fin_ok = 1'b1; fin_err = ERR_NONE;
        end
      endcase
    end

    if (init_end_go) begin
      fast_clock_next = init_ok;
      if (mode == M_INIT) begin
        fin = 1'b1; fin_ok = init_ok; fin_err = init_ok ? ERR_NONE : ERR_INIT;
      end else if (retry_counter_next >= att_lim(mode == M_READ ? cfg.read_attempts
                                                                : cfg.write_attempts)) begin
        fin = 1'b1; fin_ok = 1'b0; fin_err = error_hold;
      end else begin
        attempt_go = 1'b1;
      end
    end

    if (attempt_go) begin
      st_cmd = 1'b1;
      sc_code = (mode_next == M_READ) ? CMD_READ_BLK : CMD_WRITE_BLK;
      sc_arg = card_addr(address_hold_next, sdhc_flag);
      sc_crc = '0;
    end

    if (init_go) begin
      fast_clock_next = 1'b0; sdhc_flag_next = 1'b0;
      phase_next = PH_DUMMY; byte_counter_next = 10'd1;
      o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b0;
    end

    if (st_cmd) begin
      cmd_code_next = sc_code; cmd_arg_next = sc_arg; cmd_crc_next = sc_crc;
      phase_next = PH_CMD; byte_counter_next = 10'd1;
      o_sv = 1'b1; o_sb = {2'b01, sc_code}; o_cs = 1'b1;
    end

    if (trail) begin
      phase_next = PH_TRAIL;
      byte_counter_next = 10'(tr_n) - 10'd1;
      next_act_next = tr_act;
      o_sv = 1'b1; o_sb = BYTE_IDLE; o_cs = 1'b1;
    end

    if (fin) begin
      phase_next = PH_IDLE; mode_next = M_NONE;
      error_hold_next = fin_err;
    end
  end

  // The store is read at the counter value of the next beat, so the byte is
  // registered and ready when that beat arrives.
  assign store_raddr = byte_counter_next[STORE_AW-1:0];
  assign store_waddr = load_index;
  assign store_wdata = write_byte;

  always_comb begin
    res.send_valid   = o_sv;
    res.send_byte    = o_sb;
    res.chip_select  = o_cs;
    res.slow_clock   = !fast_clock_next;
    res.read_valid   = o_rv;
    res.read_byte    = o_rb;
    res.read_last    = o_rl;
    res.done_res     = fin;
    res.success      = fin & fin_ok;
    res.error_code   = fin ? fin_err : ERR_NONE;
    res.is_sdhc      = sdhc_flag_next;
    res.card_version = version_hold_next;
  end

endmodule

// ===== rtl/core/sd_card_spi_host_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Runs card init, single-block read and verified single-block write, one
// card byte per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | operation, block_address, write_byte,
//           |                      | card_byte
//  out      | out_valid/ out_ready | send/read/done fields, is_sdhc, version
//  config   | cfg_we               | cfg_index, cfg_data
//
// Every input beat yields one output beat in the next cycle; a new beat is taken
// each cycle while the output register is free or being drained.
// The block store is a 512 x 8 RAM read one beat ahead of its use.
// Reset clears all control state; the store holds garbage until loaded.
// A stalled output holds its beat and stops input acceptance.
module sd_card_spi_host_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] block_address,
  input  logic [7:0]  write_byte,
  input  logic [7:0]  card_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_valid,
  output logic [7:0]  send_byte,
  output logic        chip_select,
  output logic        slow_clock,
  output logic        read_valid,
  output logic [7:0]  read_byte,
  output logic        read_last,
  output logic        done_res,
  output logic        success,
  output logic [2:0]  error_code,
  output logic        is_sdhc,
  output logic [1:0]  card_version,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import sdhs_pkg::*;

  cfg_t                cfg;
  res_t                res, res_q;
  logic                fire;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [7:0]          store_wdata, store_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.r1_poll_limit      <= 16'd2500;
      cfg.token_poll_limit   <= 16'd10000;
      cfg.busy_poll_limit    <= 20'd1000000;
      cfg.init_attempt_limit <= 16'd1000;
      cfg.read_attempts      <= 4'd4;
      cfg.write_attempts     <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R1_POLL:    cfg.r1_poll_limit      <= cfg_data[15:0];
        REG_TOKEN_POLL: cfg.token_poll_limit   <= cfg_data[15:0];
        REG_BUSY_POLL:  cfg.busy_poll_limit    <= cfg_data;
        REG_INIT_ATT:   cfg.init_attempt_limit <= cfg_data[15:0];
        REG_READ_ATT:   cfg.read_attempts      <= cfg_data[3:0];
        REG_WRITE_ATT:  cfg.write_attempts     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  sdhs_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  sdhs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .operation     (operation),
    .block_address (block_address),
    .write_byte    (write_byte),
    .card_byte     (card_byte),
    .cfg           (cfg),
    .store_rdata   (store_rdata),
    .store_we      (store_we),
    .store_waddr   (store_waddr),
    .store_wdata   (store_wdata),
    .store_raddr   (store_raddr),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign send_valid   = res_q.send_valid;
  assign send_byte    = res_q.send_byte;
  assign chip_select  = res_q.chip_select;
  assign slow_clock   = res_q.slow_clock;
  assign read_valid   = res_q.read_valid;
  assign read_byte    = res_q.read_byte;
  assign read_last    = res_q.read_last;
  assign done_res     = res_q.done_res;
  assign success      = res_q.success;
  assign error_code   = res_q.error_code;
  assign is_sdhc      = res_q.is_sdhc;
  assign card_version = res_q.card_version;

endmodule

// ===== rtl/core/sdhs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI host sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sdhs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       send_valid,
  input logic [7:0] send_byte,
  input logic       chip_select,
  input logic       read_valid,
  input logic       done_res,
  input logic       success,
  input logic [2:0] error_code
);
  import sdhs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(send_byte))
    else $error("stalled output beat changed");

  a_cs_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_valid |-> !chip_select)
    else $error("card selected with no byte to send");

  a_read_sends: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> send_valid && chip_select)
    else $error("read byte without a following transfer");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> success == (error_code == ERR_NONE))
    else $error("completion status disagrees with error code");

endmodule

bind sd_card_spi_host_sequencer sdhs_checker u_sdhs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .send_valid  (send_valid),
  .send_byte   (send_byte),
  .chip_select (chip_select),
  .read_valid  (read_valid),
  .done_res    (done_res),
  .success     (success),
  .error_code  (error_code)
);
